@@ design/mdv_pkg.sv @@
package mdv_pkg;

	typedef enum logic {
		OP_STORE,
		OP_DROP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic last;
		logic dropped;
	} ctl_t;

endpackage

@@ design/mdv_fifo.sv @@
module mdv_fifo #(
	parameter int WIDTH = 8,
	parameter int LOG2  = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int N = 1 << LOG2;

	logic [WIDTH-1:0] mem_q [N];
	logic [LOG2-1:0]  wr_ptr_q;
	logic [LOG2-1:0]  rd_ptr_q;
	logic [LOG2:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == (LOG2+1)'(N);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + LOG2'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + LOG2'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (LOG2+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (LOG2+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

@@ design/mdv_front.sv @@
module mdv_front #(
	parameter int DEPTH       = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                accept,
	input  logic signed [SAMPLE_BITS-1:0]                       sample,
	input  logic                                                last,
	output mdv_pkg::ctl_t                                       ctl,
	output logic [$clog2(DEPTH)-1:0]                            addr,
	output logic signed [SAMPLE_BITS+$clog2(DEPTH+1)-1:0]       sum,
	output logic [$clog2(DEPTH+1)-1:0]                          count
);
	import mdv_pkg::*;

	localparam int CW   = $clog2(DEPTH+1);
	localparam int AW   = $clog2(DEPTH);
	localparam int SUMW = SAMPLE_BITS + CW;

	logic [CW-1:0]          fill_q;
	logic signed [SUMW-1:0] sum_q;
	logic                   drop_q;
	logic                   keep;

	always_comb begin
		keep        = fill_q != CW'(DEPTH);
		ctl.op      = keep ? OP_STORE : OP_DROP;
		ctl.last    = last;
		ctl.dropped = drop_q | ~keep;
		addr        = fill_q[AW-1:0];
		count       = fill_q + CW'(keep);
		sum         = keep ? sum_q + SUMW'(sample) : sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				fill_q <= '0;
				sum_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				fill_q <= count;
				sum_q  <= sum;
				drop_q <= ctl.dropped;
			end
		end
	end

endmodule

@@ design/mdv_div.sv @@
module mdv_div #(
	parameter int NW = 42,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int KW = $clog2(NW+1);

	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign ge       = trial >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

@@ design/mdv_back.sv @@
module mdv_back #(
	parameter int DEPTH       = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          q_empty,
	output logic                                          q_pop,
	input  mdv_pkg::ctl_t                                 ctl,
	input  logic [$clog2(DEPTH)-1:0]                      addr,
	input  logic [SAMPLE_BITS-1:0]                        sample,
	input  logic signed [SAMPLE_BITS+$clog2(DEPTH+1)-1:0] sum,
	input  logic [$clog2(DEPTH+1)-1:0]                    count,
	input  logic                                          pop,
	output logic                                          empty,
	output logic [15:0]                                   mean,
	output logic [15:0]                                   mean_abs_dev,
	output logic [31:0]                                   variance,
	output logic [7:0]                                    sample_count,
	output logic                                          overflow
);
	import mdv_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(DEPTH+1);
	localparam int AW   = $clog2(DEPTH);
	localparam int SUMW = SB + CW;
	localparam int ABW  = SB + CW;
	localparam int SQW  = 2*SB + CW;
	localparam int NW   = SQW;
	localparam int MXW  = (SB > 16) ? SB : 16;
	localparam int QXW  = (NW > 32) ? NW : 32;
	localparam int CXW  = (CW > 8) ? CW : 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_PASS,
		ST_ABS,
		ST_SQ,
		ST_PUT
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        n_q;
	logic                 neg_q;
	logic                 drop_q;
	logic signed [SB-1:0] mean_q;
	logic [15:0]          abs_res_q;
	logic [CW-1:0]        iss_q;
	logic                 out_valid_q;
	logic [15:0]          mean_out_q;
	logic [15:0]          mad_out_q;
	logic [31:0]          var_out_q;
	logic [7:0]           cnt_out_q;
	logic                 ovf_out_q;

	logic [SB-1:0]        store [DEPTH];
	logic signed [SB-1:0] rd_data_q;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic [SB-1:0]        ad_s2;
	logic [SB-1:0]        ad_s3;
	logic [2*SB-1:0]      sq_s3;
	logic [ABW-1:0]       abs_acc_q;
	logic [SQW-1:0]       sq_acc_q;

	logic                 wr_en;
	logic                 rd_en;
	logic                 pass_done;
	logic                 div_start;
	logic [NW-1:0]        div_dividend;
	logic [CW-1:0]        div_den;
	logic                 div_done;
	logic [NW-1:0]        div_quo;
	logic [SUMW-1:0]      sum_mag;
	logic [SB-1:0]        q_lo;
	logic signed [SB-1:0] mean_nxt;
	logic signed [MXW-1:0] mean_x;
	logic [QXW-1:0]       quo_x;
	logic [CXW-1:0]       cnt_x;
	logic signed [SB:0]   diff;
	logic [SB-1:0]        ad;

	mdv_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && !q_empty;
		wr_en     = q_pop && (ctl.op == OP_STORE);
		rd_en     = (state_q == ST_PASS) && (iss_q != n_q);
		pass_done = (state_q == ST_PASS) && (iss_q == n_q) && !v_s1 && !v_s2 && !v_s3;
		div_den   = (state_q == ST_IDLE) ? count : n_q;
		sum_mag   = sum[SUMW-1] ? (~sum + SUMW'(1)) : sum;
		q_lo      = div_quo[SB-1:0];
		mean_nxt  = neg_q ? (~q_lo + SB'(1)) : q_lo;
		mean_x    = MXW'(mean_q);
		quo_x     = QXW'(div_quo);
		cnt_x     = CXW'(n_q);
		diff      = (SB+1)'(rd_data_q) - (SB+1)'(mean_q);
		ad        = diff[SB] ? SB'(-diff) : SB'(diff);
		unique case (state_q)
			ST_IDLE: begin
				div_start    = q_pop && ctl.last;
				div_dividend = NW'(sum_mag);
			end
			ST_PASS: begin
				div_start    = pass_done;
				div_dividend = NW'(abs_acc_q);
			end
			ST_ABS: begin
				div_start    = div_done;
				div_dividend = sq_acc_q;
			end
			default: begin
				div_start    = 1'b0;
				div_dividend = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			neg_q       <= 1'b0;
			drop_q      <= 1'b0;
			mean_q      <= '0;
			abs_res_q   <= '0;
			iss_q       <= '0;
			out_valid_q <= 1'b0;
			mean_out_q  <= '0;
			mad_out_q   <= '0;
			var_out_q   <= '0;
			cnt_out_q   <= '0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && ctl.last) begin
						n_q     <= count;
						neg_q   <= sum[SUMW-1];
						drop_q  <= ctl.dropped;
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						mean_q  <= mean_nxt;
						iss_q   <= '0;
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (rd_en)
						iss_q <= iss_q + CW'(1);
					if (pass_done)
						state_q <= ST_ABS;
				end
				ST_ABS: begin
					if (div_done) begin
						abs_res_q <= quo_x[15:0];
						state_q   <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (div_done)
						state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (!out_valid_q || pop) begin
						out_valid_q <= 1'b1;
						mean_out_q  <= mean_x[15:0];
						mad_out_q   <= abs_res_q;
						var_out_q   <= quo_x[31:0];
						cnt_out_q   <= cnt_x[7:0];
						ovf_out_q   <= drop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store[addr] <= sample;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= store[iss_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// scan: read, |x - mean|, square, accumulate
	always_ff @(posedge clk) begin
		ad_s2 <= ad;
		ad_s3 <= ad_s2;
		sq_s3 <= (2*SB)'(ad_s2) * (2*SB)'(ad_s2);
		if (state_q == ST_MEAN && div_done) begin
			abs_acc_q <= '0;
			sq_acc_q  <= '0;
		end else if (v_s3) begin
			abs_acc_q <= abs_acc_q + ABW'(ad_s3);
			sq_acc_q  <= sq_acc_q + SQW'(sq_s3);
		end
	end

	assign empty        = !out_valid_q;
	assign mean         = mean_out_q;
	assign mean_abs_dev = mad_out_q;
	assign variance     = var_out_q;
	assign sample_count = cnt_out_q;
	assign overflow     = ovf_out_q;

endmodule

@@ design/mean_deviation_variance_unit.sv @@
// channel   handshake          payload
// input     push / full        sample, last
// result    pop / empty        mean, mean_abs_dev, variance, sample_count, overflow
//
// While full is low, samples load at one per cycle through a 4-entry request queue into
// the store. Popping the request that closes a set of n kept samples starts three runs of
// the bit-serial divider, W = 2*SAMPLE_BITS + clog2(DEPTH+1) bits wide (40 by default),
// and one scan of the store.
// Meanwhile the queue takes up to four requests of the next set, then full holds the input.
// No clearing pass after reset; a finished result holds until popped, stalling the back end.
module mean_deviation_variance_unit #(
	parameter int DEPTH       = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [15:0]            mean,
	output logic [15:0]                   mean_abs_dev,
	output logic [31:0]                   variance,
	output logic [7:0]                    sample_count,
	output logic                          overflow
);
	import mdv_pkg::*;

	localparam int CW   = $clog2(DEPTH+1);
	localparam int AW   = $clog2(DEPTH);
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int CTW  = $bits(ctl_t);
	localparam int QW   = CTW + AW + SAMPLE_BITS + SUMW + CW;

	logic                   accept;
	ctl_t                   f_ctl;
	logic [AW-1:0]          f_addr;
	logic signed [SUMW-1:0] f_sum;
	logic [CW-1:0]          f_count;
	logic [QW-1:0]          q_wdata;
	logic [QW-1:0]          q_rdata;
	logic                   q_empty;
	logic                   q_pop;
	ctl_t                   b_ctl;
	logic [AW-1:0]          b_addr;
	logic [SAMPLE_BITS-1:0] b_sample;
	logic signed [SUMW-1:0] b_sum;
	logic [CW-1:0]          b_count;
	logic [15:0]            b_mean;

	assign accept  = push && !full;
	assign q_wdata = {f_ctl, f_addr, sample, f_sum, f_count};
	assign {b_ctl, b_addr, b_sample, b_sum, b_count} = q_rdata;
	assign mean    = b_mean;

	mdv_front #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.last   (last),
		.ctl    (f_ctl),
		.addr   (f_addr),
		.sum    (f_sum),
		.count  (f_count)
	);

	mdv_fifo #(
		.WIDTH (QW),
		.LOG2  (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	mdv_back #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.ctl          (b_ctl),
		.addr         (b_addr),
		.sample       (b_sample),
		.sum          (b_sum),
		.count        (b_count),
		.pop          (pop),
		.empty        (empty),
		.mean         (b_mean),
		.mean_abs_dev (mean_abs_dev),
		.variance     (variance),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

endmodule
